[src/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 helper for the reply decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned TEMP_W  = 15;
	localparam int unsigned HUMI_W  = 14;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned OUT_USER_W = 2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	// Temperature: floor(17500*raw/65536) - 4500, humidity: floor(10000*raw/65536).
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUMI_SCALE  = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;

	// Byte positions within one reply.
	localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
	localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
	localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
	localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

	typedef struct packed {
		logic [WORD_W-1:0] temp_word;
		logic [WORD_W-1:0] humi_word;
		logic              temp_ok;
		logic              humi_ok;
	} raw_reading_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centi;
		logic        [HUMI_W-1:0] humidity_centi;
		logic                     temp_crc_ok;
		logic                     humi_crc_ok;
	} reading_t;

	// One byte of CRC-8, MSB first, no reflection.
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
	                                                input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[src/htfd_convert.sv]
// ----------------------------------------------------------------------------
// htfd_convert
// Scales the raw temperature and humidity words to hundredths.
// ----------------------------------------------------------------------------
module htfd_convert import htfd_pkg::*; (
	input  raw_reading_t raw,
	output reading_t     reading
);

	logic [30:0] temp_prod;
	logic [29:0] humi_prod;
	logic [15:0] temp_scaled;

	// A word that failed its check arrives here as zero already.
	assign temp_prod   = 31'(TEMP_SCALE) * 31'(raw.temp_word);
	assign humi_prod   = 30'(HUMI_SCALE) * 30'(raw.humi_word);
	assign temp_scaled = {1'b0, temp_prod[30:16]} - TEMP_OFFSET;

	always_comb begin
		reading.temperature_centi = signed'(temp_scaled[TEMP_W-1:0]);
		reading.humidity_centi    = humi_prod[29:16];
		reading.temp_crc_ok       = raw.temp_ok;
		reading.humi_crc_ok       = raw.humi_ok;
	end

endmodule

[src/humidity_temp_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes six-byte humidity/temperature sensor replies into scaled readings.
// ----------------------------------------------------------------------------
// The block takes the bytes of a sensor reply one item at a time on the slave
// stream: temperature high, temperature low, temperature CRC, humidity high,
// humidity low, humidity CRC. Each word is checked with CRC-8 (polynomial 0x31,
// initial value 0xFF, no reflection); a word that fails is taken as zero and its
// ok flag is cleared. After the sixth byte one reading is sent on the master
// stream: temperature in hundredths of a degree Celsius and relative humidity in
// hundredths of a percent, both with floor rounding. Setting tuser on a byte
// marks it as the first of a reply and drops any partial reply; without it the
// position simply wraps after six bytes. A byte is registered on entry and
// decoded from that input register, and the reading that a sixth byte
// completes is written to the output register and offered from there. One
// byte is accepted per clock cycle; the only thing that holds the input back
// is a finished reading still waiting in the output register while the next
// sixth byte wants to leave.
module humidity_temp_frame_decoder import htfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
	input  logic                  s_axis_tuser,  // [0] frame_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [14:0] temperature_centi,
	                                             // [28:15] humidity_centi, rest zero
	output logic [OUT_USER_W-1:0] m_axis_tuser   // [0] temp_crc_ok, [1] humi_crc_ok
);

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	// Decoder state.
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] high_q;
	logic [WORD_W-1:0] temp_word_q;
	logic [WORD_W-1:0] humi_word_q;
	logic              temp_ok_q;

	// Output register.
	logic              out_valid_q;
	reading_t          reading_q;

	logic [POS_W-1:0]  cur_pos;
	logic [BYTE_W-1:0] crc_next;
	logic              crc_match;
	logic              emit;
	logic              advance;
	raw_reading_t      raw;
	reading_t          reading;

	// A byte that carries the start flag, or an impossible position, restarts
	// the reply at the temperature high byte.
	assign cur_pos = (start_s1 || pos_q > POS_H_CRC) ? POS_T_HI : pos_q;

	// The high bytes start a fresh CRC; the low bytes continue it.
	assign crc_next  = crc8_byte((cur_pos == POS_T_HI || cur_pos == POS_H_HI) ? CRC_INIT
	                             : crc_q, byte_s1);
	assign crc_match = (crc_q == byte_s1);

	assign emit    = valid_s1 && (cur_pos == POS_H_CRC);
	// The registered byte moves on unless it would produce a reading while the
	// previous one is still waiting to be taken.
	assign advance = !(emit && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		raw.temp_word = temp_word_q;
		raw.humi_word = crc_match ? humi_word_q : '0;
		raw.temp_ok   = temp_ok_q;
		raw.humi_ok   = crc_match;
	end

	htfd_convert u_convert (
		.raw     (raw),
		.reading (reading)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_T_HI;
			crc_q       <= CRC_INIT;
			high_q      <= '0;
			temp_word_q <= '0;
			humi_word_q <= '0;
			temp_ok_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			pos_q <= (cur_pos == POS_H_CRC) ? POS_T_HI : cur_pos + POS_W'(1);
			case (cur_pos)
				POS_T_HI, POS_H_HI: begin
					crc_q  <= crc_next;
					high_q <= byte_s1;
				end
				POS_T_LO: begin
					crc_q       <= crc_next;
					temp_word_q <= {high_q, byte_s1};
				end
				POS_H_LO: begin
					crc_q       <= crc_next;
					humi_word_q <= {high_q, byte_s1};
				end
				POS_T_CRC: begin
					temp_ok_q <= crc_match;
					if (!crc_match) begin
						temp_word_q <= '0;
					end
				end
				default: begin
					if (!crc_match) begin
						humi_word_q <= '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && advance) begin
			reading_q <= reading;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, reading_q.humidity_centi, reading_q.temperature_centi};
	assign m_axis_tuser  = {reading_q.humi_crc_ok, reading_q.temp_crc_ok};

`ifndef NO_ASSERTIONS
	// A failed temperature check must read as the bottom of the range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[14:0] == 15'h6E6C))
		else $error("temperature not forced low after CRC failure");

	// A failed humidity check must read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[28:15] == '0))
		else $error("humidity not forced to zero after CRC failure");

	// The byte position never leaves the six legal values.
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_H_CRC)
		else $error("byte position out of range");

	// Consuming a humidity CRC byte always leaves a reading in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && advance) |=> (m_axis_tvalid && pos_q == POS_T_HI))
		else $error("reading lost after sixth byte");
`endif

endmodule
